[rtl/multitap_button_decoder_unit_macros.svh]
// Assertion macros shared by the decoder RTL.
// Each macro takes a label, a clock, a reset, a condition, a consequence and a message.
`ifndef MULTITAP_BUTTON_DECODER_UNIT_MACROS_SVH
`define MULTITAP_BUTTON_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define MTBD_ASSERT_SAME(lbl, ck, rs, cond, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |-> (cons)) else $error(msg);

// The consequence must hold in the cycle after the condition.
`define MTBD_ASSERT_NEXT(lbl, ck, rs, cond, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (cons)) else $error(msg);

`else

`define MTBD_ASSERT_SAME(lbl, ck, rs, cond, cons, msg)
`define MTBD_ASSERT_NEXT(lbl, ck, rs, cond, cons, msg)

`endif

`endif

[rtl/mtbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mtbd_pkg;

  // Default width of the window and hold timers.
  localparam int TICK_WIDTH_DEF = 16;

  // Width of each configuration register.
  localparam int CFG_WIDTH = 16;

  // Register reset values.
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 16'd500;
  localparam logic [CFG_WIDTH-1:0] HOLD_RESET   = 16'd100;

  // Register indexes on the configuration port.
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_HOLD   = 1'b1;

  // The tap counter saturates at this value.
  localparam logic [2:0] TAP_MAX = 3'd4;

  // Decoder phases.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_ASSERT  = 2'd2
  } phase_t;

  // Effector combination: bit 0 is E2, bit 1 is E3, bit 2 is E4.
  localparam logic [2:0] COMBO_NONE  = 3'b000;
  localparam logic [2:0] COMBO_E2    = 3'b001;
  localparam logic [2:0] COMBO_E3    = 3'b010;
  localparam logic [2:0] COMBO_E2_E3 = 3'b011;
  localparam logic [2:0] COMBO_E4    = 3'b100;

  // Map a tap count to the effector combination it selects.
  function automatic logic [2:0] decode_taps(input logic [2:0] taps);
    logic [2:0] combo;
    unique case (taps)
      3'd0:    combo = COMBO_NONE;
      3'd1:    combo = COMBO_E2;
      3'd2:    combo = COMBO_E3;
      3'd3:    combo = COMBO_E2_E3;
      default: combo = COMBO_E4;
    endcase
    return combo;
  endfunction

endpackage

`default_nettype wire

[rtl/multitap_button_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word layout (lowest bit first)
// s_axis    in   tdata[0] pressed, tdata[7:1] zero
// m_axis    out  tdata[0] assert_e2, [1] assert_e3, [2] assert_e4,
//                [4:3] phase_now, [7:5] zero
// cfg       in   cfg_index 0 capture_window_ticks, 1 hold_ticks
//
// One word is taken per clock cycle unless the output stalls; its result appears in the
// output register on the next cycle, and throughput is one word per cycle.
// The rate is set by the single state update between the phase/timer registers and
// the output register.
// A stalled output holds its word; a new input word is still taken in the cycle the
// held word leaves. rst is synchronous and returns the phase to idle with the
// registers at their default values.

`include "multitap_button_decoder_unit_macros.svh"

module multitap_button_decoder_unit #(
  parameter int TICK_WIDTH = mtbd_pkg::TICK_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,  // [0] pressed
  // Output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [7:0]                          m_tdata,  // [0] e2, [1] e3, [2] e4, [4:3] phase
  // Configuration write port
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [mtbd_pkg::CFG_WIDTH-1:0] cfg_data
);

  localparam int EXT_W = 2 * mtbd_pkg::CFG_WIDTH;

  // Configuration registers.
  logic [mtbd_pkg::CFG_WIDTH-1:0] capture_window_ticks;
  logic [mtbd_pkg::CFG_WIDTH-1:0] hold_ticks;

  // Decoder state.
  mtbd_pkg::phase_t  phase, phase_next;
  logic              previous_level, previous_level_next;
  logic [2:0]        tap_count, tap_count_next;
  logic [TICK_WIDTH-1:0] ticks_left, ticks_left_next;
  logic [2:0]        asserted_combo, asserted_combo_next;

  // Output register.
  logic [7:0]        result_word;

  logic              level;
  logic              s_accept;
  logic [EXT_W-1:0]  window_ext;
  logic [EXT_W-1:0]  hold_ext;
  logic [TICK_WIDTH-1:0] window_load;
  logic [TICK_WIDTH-1:0] hold_load;

  // Handshake: a word is taken whenever the output register is free or draining.
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign level    = s_tdata[0];

  // Register values fitted to the timer width.
  assign window_ext  = {{(EXT_W - mtbd_pkg::CFG_WIDTH){1'b0}}, capture_window_ticks};
  assign hold_ext    = {{(EXT_W - mtbd_pkg::CFG_WIDTH){1'b0}}, hold_ticks};
  assign window_load = window_ext[TICK_WIDTH-1:0];
  assign hold_load   = hold_ext[TICK_WIDTH-1:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_window_ticks <= mtbd_pkg::WINDOW_RESET;
      hold_ticks           <= mtbd_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mtbd_pkg::REG_WINDOW: capture_window_ticks <= cfg_data;
        default:              hold_ticks           <= cfg_data;
      endcase
    end
  end

  // Next state for one tick: timer count-down, edge capture, window and hold expiry.
  always_comb begin
    phase_next          = phase;
    previous_level_next = previous_level;
    tap_count_next      = tap_count;
    ticks_left_next     = ticks_left;
    asserted_combo_next = asserted_combo;

    if (phase != mtbd_pkg::PH_IDLE && ticks_left != '0) begin
      ticks_left_next = ticks_left - {{(TICK_WIDTH-1){1'b0}}, 1'b1};
    end

    if (phase == mtbd_pkg::PH_IDLE || phase == mtbd_pkg::PH_CAPTURE) begin
      if (!previous_level && level) begin
        if (phase == mtbd_pkg::PH_IDLE) begin
          tap_count_next  = 3'd0;
          ticks_left_next = window_load;
          phase_next      = mtbd_pkg::PH_CAPTURE;
        end
        if (tap_count_next < mtbd_pkg::TAP_MAX) begin
          tap_count_next = tap_count_next + 3'd1;
        end
      end
      previous_level_next = level;
    end

    if (phase_next == mtbd_pkg::PH_CAPTURE && ticks_left_next == '0) begin
      phase_next          = mtbd_pkg::PH_ASSERT;
      ticks_left_next     = hold_load;
      asserted_combo_next = mtbd_pkg::decode_taps(tap_count_next);
    end

    if (phase_next == mtbd_pkg::PH_ASSERT && ticks_left_next == '0) begin
      if (level) begin
        ticks_left_next = hold_load;
      end else begin
        phase_next          = mtbd_pkg::PH_IDLE;
        asserted_combo_next = mtbd_pkg::COMBO_NONE;
      end
    end
  end

  // Result word built from the state after this tick.
  logic [7:0] result_next;
  always_comb begin
    result_next = {3'b000, phase_next, asserted_combo_next};
  end

  // State registers advance once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtbd_pkg::PH_IDLE;
      previous_level <= 1'b0;
      tap_count      <= 3'd0;
      ticks_left     <= '0;
      asserted_combo <= mtbd_pkg::COMBO_NONE;
    end else if (s_accept) begin
      phase          <= phase_next;
      previous_level <= previous_level_next;
      tap_count      <= tap_count_next;
      ticks_left     <= ticks_left_next;
      asserted_combo <= asserted_combo_next;
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      result_word <= result_next;
    end
  end

  assign m_tdata = result_word;

  // Checks on the decoder state.
  `MTBD_ASSERT_SAME(a_combo_only_in_assert, clk, rst, phase != mtbd_pkg::PH_ASSERT, asserted_combo == mtbd_pkg::COMBO_NONE, "combination driven outside the assert phase")
  `MTBD_ASSERT_SAME(a_combo_set_in_assert, clk, rst, phase == mtbd_pkg::PH_ASSERT, asserted_combo != mtbd_pkg::COMBO_NONE, "assert phase with no combination")
  `MTBD_ASSERT_SAME(a_taps_in_capture, clk, rst, phase == mtbd_pkg::PH_CAPTURE, tap_count != 3'd0 && tap_count <= mtbd_pkg::TAP_MAX, "tap count out of range during capture")
  `MTBD_ASSERT_NEXT(a_history_frozen, clk, rst, s_accept && phase == mtbd_pkg::PH_ASSERT, $stable(previous_level), "edge history changed in the assert phase")
  `MTBD_ASSERT_NEXT(a_result_follows, clk, rst, s_accept, m_tvalid, "accepted word produced no result")

endmodule

`default_nettype wire

[tb/tb_multitap_button_decoder_unit.sv]
`timescale 1ns / 1ps

module tb_multitap_button_decoder_unit;

  // Result of one tick as the decoder reports it.
  typedef struct packed {
    logic [1:0] phase;
    logic       e4;
    logic       e3;
    logic       e2;
  } tick_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;  // [0] pressed, [7:1] zero
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;         // [0] e2, [1] e3, [2] e4, [4:3] phase, [7:5] zero
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = mtbd_pkg::REG_WINDOW;
  logic [mtbd_pkg::CFG_WIDTH-1:0] cfg_data = '0;

  // Decoder state as predicted by the testbench.
  mtbd_pkg::phase_t     dec_phase;
  logic                 dec_prev;
  logic [2:0]           dec_taps;
  logic [15:0]          dec_left;
  logic [2:0]           dec_combo;
  logic [15:0]          window_ticks;
  logic [15:0]          hold_len;

  tick_result_t         expected_words[$];
  tick_result_t         want;
  int                   mismatch_count = 0;
  int                   ticks_sent = 0;
  int                   idle_pct = 0;
  int                   stall_pct = 0;

  multitap_button_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Advance the predicted decoder by one tick and return what it should report.
  function automatic tick_result_t predict_tick(input logic lvl);
    tick_result_t res;
    if (dec_phase != mtbd_pkg::PH_IDLE && dec_left != 16'd0) begin
      dec_left = dec_left - 16'd1;
    end
    if (dec_phase == mtbd_pkg::PH_IDLE || dec_phase == mtbd_pkg::PH_CAPTURE) begin
      if (!dec_prev && lvl) begin
        if (dec_phase == mtbd_pkg::PH_IDLE) begin
          dec_taps  = 3'd0;
          dec_left  = window_ticks;
          dec_phase = mtbd_pkg::PH_CAPTURE;
        end
        if (dec_taps < mtbd_pkg::TAP_MAX) begin
          dec_taps = dec_taps + 3'd1;
        end
      end
      dec_prev = lvl;
    end
    // Window closed: pick the combination from the tap count.
    if (dec_phase == mtbd_pkg::PH_CAPTURE && dec_left == 16'd0) begin
      dec_phase = mtbd_pkg::PH_ASSERT;
      dec_left  = hold_len;
      case (dec_taps)
        3'd0:    dec_combo = mtbd_pkg::COMBO_NONE;
        3'd1:    dec_combo = mtbd_pkg::COMBO_E2;
        3'd2:    dec_combo = mtbd_pkg::COMBO_E3;
        3'd3:    dec_combo = mtbd_pkg::COMBO_E2_E3;
        default: dec_combo = mtbd_pkg::COMBO_E4;
      endcase
    end
    // Hold expired: re-arm while pressed, otherwise release everything.
    if (dec_phase == mtbd_pkg::PH_ASSERT && dec_left == 16'd0) begin
      if (lvl) begin
        dec_left = hold_len;
      end else begin
        dec_phase = mtbd_pkg::PH_IDLE;
        dec_combo = mtbd_pkg::COMBO_NONE;
      end
    end
    res.e2    = dec_combo[0];
    res.e3    = dec_combo[1];
    res.e4    = dec_combo[2];
    res.phase = dec_phase;
    return res;
  endfunction

  task automatic note_failure(input string what, input logic [2:0] exp_v, input logic [2:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    end
  endtask

  // Receiver stalls at the rate that stall_pct sets for the current test.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted output word is compared with the oldest prediction.
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        note_failure("word with nothing expected", 3'd0, m_tdata[2:0]);
      end else begin
        want = expected_words.pop_front();
        if (m_tdata[0] !== want.e2) begin
          note_failure("assert_e2", {2'b00, want.e2}, {2'b00, m_tdata[0]});
        end
        if (m_tdata[1] !== want.e3) begin
          note_failure("assert_e3", {2'b00, want.e3}, {2'b00, m_tdata[1]});
        end
        if (m_tdata[2] !== want.e4) begin
          note_failure("assert_e4", {2'b00, want.e4}, {2'b00, m_tdata[2]});
        end
        if (m_tdata[4:3] !== want.phase) begin
          note_failure("phase_now", {1'b0, want.phase}, {1'b0, m_tdata[4:3]});
        end
        if (m_tdata[7:5] !== 3'd0) note_failure("padding", 3'd0, m_tdata[7:5]);
      end
    end
  end

  // Send one tick word, with a random gap in front of it when idling is on.
  // Valid stays high afterwards so that back-to-back words need no toggle.
  task automatic send_tick(input logic lvl);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lvl};
    do @(negedge clk); while (!s_tready);
    expected_words.push_back(predict_tick(lvl));
    @(posedge clk);
    ticks_sent++;
  endtask

  task automatic play(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Stop sending and wait until every predicted word has come out.
  task automatic drain_words();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    drain_words();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mtbd_pkg::REG_WINDOW) window_ticks = value;
    else hold_len = value;
  endtask

  // Mostly short timings so that many gestures fit, now and then the minimum or longer.
  function automatic logic [15:0] pick_len();
    case ($urandom_range(9))
      0:       return 16'd1;
      1:       return 16'($urandom_range(13, 40));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // One tap from the reset timings: a 500 tick window, then a 100 tick hold.
  task automatic test_reset_defaults();
    idle_pct  = 0;
    stall_pct = 0;
    play(1'b1, 1);
    play(1'b0, 604);
  endtask

  // One to five taps, the window wide enough to catch them all.
  task automatic test_tap_counts();
    int n;
    for (n = 1; n <= 5; n++) begin
      write_reg(mtbd_pkg::REG_WINDOW, 16'(2 * n - 1));
      write_reg(mtbd_pkg::REG_HOLD, 16'd1);
      repeat (n) begin
        play(1'b1, 1);
        play(1'b0, 1);
      end
      play(1'b0, 2);
    end
  endtask

  // A held button keeps re-arming the hold; edges during the hold are not seen.
  task automatic test_hold_rearm();
    write_reg(mtbd_pkg::REG_WINDOW, 16'd1);
    write_reg(mtbd_pkg::REG_HOLD, 16'd3);
    play(1'b1, 9);
    play(1'b0, 1);
    play(1'b1, 1);
    play(1'b0, 5);
    write_reg(mtbd_pkg::REG_HOLD, 16'd1);
    play(1'b1, 4);
    play(1'b0, 3);
  endtask

  // Longest window and hold the registers can hold: the window stays open throughout.
  task automatic test_extremes();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(mtbd_pkg::REG_WINDOW, 16'hFFFF);
    write_reg(mtbd_pkg::REG_HOLD, 16'hFFFF);
    play(1'b1, 1);
    play(1'b0, 1);
    play(1'b1, 1);
    play(1'b0, 20);
  endtask

  // Tap gestures with random content, plus some level noise.
  task automatic random_gesture();
    int taps;
    int i;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 16)) send_tick(1'($urandom_range(1)));
    end else begin
      taps = $urandom_range(1, 6);
      for (i = 0; i < taps; i++) begin
        play(1'b1, $urandom_range(1, 3));
        play(1'b0, $urandom_range(1, 3));
      end
      if ($urandom_range(2) == 0) begin
        play(1'b1, $urandom_range(1, int'(window_ticks) + 2 * int'(hold_len) + 2));
      end
      play(1'b0, $urandom_range(0, int'(window_ticks) + int'(hold_len) + 3));
    end
  endtask

  task automatic test_random(input int idle, input int stall, input int n_items,
                             input bit pause_midway);
    int stop_at;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = ticks_sent + n_items;
    while (ticks_sent < stop_at) begin
      write_reg(mtbd_pkg::REG_WINDOW, pick_len());
      write_reg(mtbd_pkg::REG_HOLD, pick_len());
      repeat ($urandom_range(1, 3)) random_gesture();
      // Let the output side run dry before carrying on.
      if (pause_midway) drain_words();
      repeat ($urandom_range(1, 2)) random_gesture();
    end
  endtask

  initial begin
    dec_phase    = mtbd_pkg::PH_IDLE;
    dec_prev     = 1'b0;
    dec_taps     = 3'd0;
    dec_left     = 16'd0;
    dec_combo    = mtbd_pkg::COMBO_NONE;
    window_ticks = mtbd_pkg::WINDOW_RESET;
    hold_len     = mtbd_pkg::HOLD_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_tap_counts();
    test_hold_rearm();
    test_random(0, 0, 60, 1'b0);
    test_random(83, 0, 60, 1'b1);
    test_random(0, 83, 60, 1'b0);
    test_random(17, 17, 60, 1'b0);
    test_extremes();

    drain_words();
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
